// File: hdl/skf_pkg.sv
// shared types, constants and microcode table for the scalar kalman filter
`timescale 1ns / 1ps

package skf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned PcW      = 3;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned ProdW    = 52;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [GainW-1:0] GainMax = '1;
  localparam logic [GainW:0]   FracOne = 17'h10000;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DENOM,
    OP_DIV,
    OP_GAIN,
    OP_MUL_EST,
    OP_MUL_VAR,
    OP_POST,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_WAIT_IN,
    C_LOOP_CNT,
    C_WAIT_OUT
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           cnt_load;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_stat_t;

  localparam logic [PcW-1:0] PcWait = 3'd0;
  localparam logic [PcW-1:0] PcDiv  = 3'd2;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_EMIT, cond: C_WAIT_OUT, target: PcWait, cnt_load: 1'b0};
    unique case (pc)
      3'd0: w = '{op: OP_LOAD,    cond: C_WAIT_IN,  target: PcWait, cnt_load: 1'b0};
      3'd1: w = '{op: OP_DENOM,   cond: C_NEXT,     target: PcWait, cnt_load: 1'b1};
      3'd2: w = '{op: OP_DIV,     cond: C_LOOP_CNT, target: PcDiv,  cnt_load: 1'b0};
      3'd3: w = '{op: OP_GAIN,    cond: C_NEXT,     target: PcWait, cnt_load: 1'b0};
      3'd4: w = '{op: OP_MUL_EST, cond: C_NEXT,     target: PcWait, cnt_load: 1'b0};
      3'd5: w = '{op: OP_MUL_VAR, cond: C_NEXT,     target: PcWait, cnt_load: 1'b0};
      3'd6: w = '{op: OP_POST,    cond: C_NEXT,     target: PcWait, cnt_load: 1'b0};
      3'd7: w = '{op: OP_EMIT,    cond: C_WAIT_OUT, target: PcWait, cnt_load: 1'b0};
      default: w = '{op: OP_EMIT, cond: C_WAIT_OUT, target: PcWait, cnt_load: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/skf_apb_regs.sv
// apb configuration registers for process and measurement noise
`timescale 1ns / 1ps

module skf_apb_regs import skf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [DataW-1:0]    process_noise_o,
  output logic [DataW-1:0]    measure_noise_o
);

  logic [DataW-1:0] q_noise_q, r_noise_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= 32'd655;
      r_noise_q <= 32'd65536;
    end else if (wr_en) begin
      if (paddr[2]) begin
        r_noise_q <= pwdata;
      end else begin
        q_noise_q <= pwdata;
      end
    end
  end

  // byte lanes within a word are not decoded
  assign prdata          = paddr[2] ? r_noise_q : q_noise_q;
  assign process_noise_o = q_noise_q;
  assign measure_noise_o = r_noise_q;

endmodule

// File: hdl/skf_sequencer.sv
// microcode sequencer: step counter, control rom and division loop counter
`timescale 1ns / 1ps

module skf_sequencer import skf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output dp_cmd_t   cmd_o,
  output logic      in_ready_o
);

  logic [PcW-1:0]  pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  uword_t          uw;
  logic            exec;

  assign uw = ucode(pc_q);

  always_comb begin
    exec = 1'b1;
    pc_d = PcW'(pc_q + 1'b1);
    case (uw.cond)
      C_WAIT_IN: begin
        exec = stat_i.in_valid;
        pc_d = exec ? PcW'(pc_q + 1'b1) : pc_q;
      end
      C_LOOP_CNT: begin
        pc_d = (cnt_q != '0) ? uw.target : PcW'(pc_q + 1'b1);
      end
      C_WAIT_OUT: begin
        exec = stat_i.out_free;
        pc_d = exec ? uw.target : pc_q;
      end
      default: begin
        pc_d = PcW'(pc_q + 1'b1);
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (exec && uw.cnt_load) begin
      cnt_d = CntW'(DivSteps);
    end else if (uw.cond == C_LOOP_CNT && cnt_q != '0) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PcWait;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign cmd_o      = '{op: uw.op, exec: exec};
  assign in_ready_o = (uw.cond == C_WAIT_IN);

endmodule

// File: hdl/skf_datapath.sv
// filter datapath: state, restoring divider and one shared multiplier
`timescale 1ns / 1ps

module skf_datapath import skf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [DataW-1:0] measurement_i,
  input  logic [DataW-1:0] process_noise_i,
  input  logic [DataW-1:0] measure_noise_i,
  output logic [DataW-1:0] estimate_o,
  output logic [DataW-1:0] variance_o
);

  logic [DataW-1:0] est_q, est_d;
  logic [DataW-1:0] var_q, var_d;
  logic [DataW-1:0] prior_q, prior_d;
  logic [DataW:0]   diff_q, diff_d;
  logic [DataW:0]   denom_q, denom_d;
  logic [DataW+1:0] rem_q, rem_d;
  logic [GainW:0]   quo_q, quo_d;
  logic [GainW-1:0] gain_q, gain_d;
  logic [ProdW-1:0] prod_q, prod_d;

  logic [DataW:0]          prior_sum;
  logic                    ge;
  logic [DataW:0]          rsub;
  logic signed [DataW+1:0] mul_a;
  logic signed [GainW+1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic [GainW:0]          one_minus_gain;

  assign prior_sum      = {1'b0, var_q} + {1'b0, process_noise_i};
  assign ge             = rem_q >= {1'b0, denom_q};
  assign rsub           = ge ? (DataW+1)'(rem_q - {1'b0, denom_q}) : rem_q[DataW:0];
  assign one_minus_gain = FracOne - {1'b0, gain_q};

  always_comb begin
    if (cmd_i.op == OP_MUL_VAR) begin
      mul_a = $signed({2'b00, prior_q});
      mul_b = $signed({1'b0, one_minus_gain});
    end else begin
      mul_a = $signed({diff_q[DataW], diff_q});
      mul_b = $signed({2'b00, gain_q});
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    est_d   = est_q;
    var_d   = var_q;
    prior_d = prior_q;
    diff_d  = diff_q;
    denom_d = denom_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    gain_d  = gain_q;
    prod_d  = prod_q;
    if (cmd_i.exec) begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          prior_d = prior_sum[DataW] ? '1 : prior_sum[DataW-1:0];
          diff_d  = {measurement_i[DataW-1], measurement_i} - {est_q[DataW-1], est_q};
        end
        OP_DENOM: begin
          denom_d = {1'b0, prior_q} + {1'b0, measure_noise_i};
          rem_d   = {2'b00, prior_q};
          quo_d   = '0;
        end
        OP_DIV: begin
          rem_d = {rsub, 1'b0};
          quo_d = {quo_q[GainW-1:0], ge};
        end
        OP_GAIN: begin
          if (denom_q == '0) begin
            gain_d = '0;
          end else if (quo_q[GainW]) begin
            gain_d = GainMax;
          end else begin
            gain_d = quo_q[GainW-1:0];
          end
        end
        OP_MUL_EST: begin
          prod_d = mul_p;
        end
        OP_MUL_VAR: begin
          // floor of diff * gain / 2^16 added modulo 2^32
          est_d  = est_q + prod_q[DataW+15:16];
          prod_d = mul_p;
        end
        OP_POST: begin
          var_d = prod_q[DataW+15:16];
        end
        OP_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      var_q <= '0;
    end else begin
      est_q <= est_d;
      var_q <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prior_q <= prior_d;
    diff_q  <= diff_d;
    denom_q <= denom_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    gain_q  <= gain_d;
    prod_q  <= prod_d;
  end

  assign estimate_o = est_q;
  assign variance_o = var_q;

endmodule

// File: hdl/scalar_kalman_filter.sv
// top level of the scalar kalman filter with output register
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid / tready           tdata[31:0] measurement
//   m_axis    out  tvalid / tready           tdata[31:0] estimate, [63:32] error_variance
//   apb       in   psel / penable / pwrite   Q at 0x0, R at 0x4
//
// each beat runs through the microcode program from acceptance to result: the 17-step
// restoring division loop plus seven other steps
// reset clears estimate and variance to zero and sets Q and R to their defaults
// a stalled result holds in the output register; the next beat is accepted
// meanwhile and the sequencer waits on its final step until the register frees
`timescale 1ns / 1ps

module scalar_kalman_filter import skf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] measurement
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // [31:0] estimate, [63:32] error_variance
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [DataW-1:0] q_noise, r_noise, est, variance;
  dp_cmd_t          cmd;
  seq_stat_t        stat;
  logic             out_valid_q;
  logic [63:0]      out_data_q;
  logic             out_load;

  skf_apb_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .process_noise_o (q_noise),
    .measure_noise_o (r_noise)
  );

  assign stat = '{in_valid: s_axis_tvalid, out_free: (!out_valid_q || m_axis_tready)};

  skf_sequencer u_seq (
    .clk_i,
    .rst_ni,
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  skf_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i           (cmd),
    .measurement_i   (s_axis_tdata),
    .process_noise_i (q_noise),
    .measure_noise_i (r_noise),
    .estimate_o      (est),
    .variance_o      (variance)
  );

  assign out_load = cmd.exec && (cmd.op == OP_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {variance, est};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: dv/tb_scalar_kalman_filter.sv
// self-checking testbench for the scalar kalman filter: directed table, then random phases
`timescale 1ns / 1ps

module tb_scalar_kalman_filter import skf_pkg::*;;

  localparam logic [ApbAddrW-1:0] AddrProcNoise = 3'd0;
  localparam logic [ApbAddrW-1:0] AddrMeasNoise = 3'd4;
  localparam logic [31:0] ResetProcNoise = 32'd655;
  localparam logic [31:0] ResetMeasNoise = 32'd65536;
  localparam int unsigned NumPhases = 16;
  localparam int unsigned BeatsPerPhase = 103;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [31:0] est;
    logic [31:0] variance;
  } kf_out_t;

  typedef struct packed {
    logic        set_cfg;
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] meas;
    logic        fixed;
    logic [31:0] est;
    logic [31:0] variance;
  } dir_row_t;

  localparam int unsigned NumDirRows = 22;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // zero denominator straight after reset: nothing moves
    '{1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0000_0000, 1'b1, 32'h0, 32'h0},
    // gain saturates below one, prior saturates
    '{1'b1, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    // default noise values
    '{1'b1, ResetProcNoise, ResetMeasNoise, 32'h0001_0000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    // huge measurement noise, tiny gain
    '{1'b1, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    // negative differences round toward minus infinity
    '{1'b1, 32'h0001_0000, 32'h0001_0000, 32'h1234_5678, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'hEDCB_A988, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    // variance decays to zero, then zero denominator mid-run
    '{1'b1, 32'h0, 32'h0, 32'h4000_0000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'hC000_0000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h0, 32'h0, 32'h0000_0001, 1'b0, 32'h0, 32'h0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [63:0]         m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  logic sink_ready;
  logic sink_hold;

  logic [31:0] model_est;
  logic [31:0] model_var;
  logic [31:0] model_q;
  logic [31:0] model_r;

  kf_out_t expected_outputs [$];
  int unsigned errors;

  assign m_axis_tready = sink_ready & ~sink_hold;

  scalar_kalman_filter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic kf_out_t kalman_update(input logic [31:0] meas);
    logic [63:0] prior;
    logic [63:0] denom;
    logic [63:0] gain;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] post;
    longint      diff;
    longint      delta;
    longint      est;
    kf_out_t     res;
    prior = 64'(model_var) + 64'(model_q);
    if (prior > 64'hFFFF_FFFF) begin
      prior = 64'hFFFF_FFFF;
    end
    denom = prior + 64'(model_r);
    if (denom == 64'd0) begin
      gain = 64'd0;
    end else begin
      gain = (prior << 16) / denom;
      if (gain > 64'(GainMax)) begin
        gain = 64'(GainMax);
      end
    end
    diff = longint'($signed(meas)) - longint'($signed(model_est));
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * gain;
    if (diff < 0) begin
      delta = -longint'((prod + 64'd65535) >> 16);
    end else begin
      delta = longint'(prod >> 16);
    end
    est = longint'($signed(model_est)) + delta;
    post = (prior * (64'd65536 - gain)) >> 16;
    res.est = est[31:0];
    res.variance = post[31:0];
    return res;
  endfunction

  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(input logic [ApbAddrW-1:0] addr, input logic [31:0] exp_data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_data) begin
      if (errors < 10) begin
        $display("register 0x%0h: expected %08h, got %08h", addr, exp_data, prdata);
      end
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
    apb_write(AddrProcNoise, q);
    apb_write(AddrMeasNoise, r);
    apb_check(AddrProcNoise, q);
    apb_check(AddrMeasNoise, r);
    model_q = q;
    model_r = r;
  endtask

  // drops valid and waits until every result has been taken
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk_i);
  endtask

  // called at a rising edge; returns at the edge that took the beat
  task automatic send_meas(input logic [31:0] meas, input logic fixed,
                           input kf_out_t fixed_out);
    int unsigned gap;
    kf_out_t     pred;
    gap = $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= meas;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = kalman_update(meas);
    model_est = pred.est;
    model_var = pred.variance;
    expected_outputs.push_back(fixed ? fixed_out : pred);
  endtask

  function automatic logic [31:0] pick_noise();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h0;
      1: v = 32'hFFFF_FFFF;
      2: v = $urandom_range(0, 65535);
      3: v = $urandom_range(0, 1 << 22);
      4: v = ResetProcNoise;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_meas();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h0;
        endcase
      end
      1, 2: v = model_est + $urandom_range(0, 1 << 21) - (1 << 20);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // result side: random stall before each beat
  initial begin
    int unsigned stall;
    sink_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, 14);
      if (stall > 0) begin
        sink_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      sink_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    kf_out_t exp_out;
    kf_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.est      = m_axis_tdata[31:0];
      got.variance = m_axis_tdata[63:32];
      if (expected_outputs.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected beat: estimate %08h variance %08h", got.est, got.variance);
        end
        errors++;
      end else begin
        exp_out = expected_outputs.pop_front();
        if (got.est !== exp_out.est || got.variance !== exp_out.variance) begin
          if (errors < 10) begin
            $display("mismatch: estimate exp %08h got %08h, variance exp %08h got %08h",
                     exp_out.est, got.est, exp_out.variance, got.variance);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    kf_out_t fixed_out;
    errors        = 0;
    sink_hold     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    model_est     = '0;
    model_var     = '0;
    model_q       = ResetProcNoise;
    model_r       = ResetMeasNoise;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_check(AddrProcNoise, ResetProcNoise);
    apb_check(AddrMeasNoise, ResetMeasNoise);

    for (int i = 0; i < NumDirRows; i++) begin
      if (DirRows[i].set_cfg) begin
        wait_idle();
        set_noise(DirRows[i].q, DirRows[i].r);
      end
      fixed_out.est      = DirRows[i].est;
      fixed_out.variance = DirRows[i].variance;
      send_meas(DirRows[i].meas, DirRows[i].fixed, fixed_out);
    end

    fixed_out = '0;
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      set_noise(pick_noise(), pick_noise());
      for (int k = 0; k < BeatsPerPhase; k++) begin
        // long sink stall so the block backs up into its input
        if (p == 3 && k == 20) begin
          fork
            begin
              sink_hold <= 1'b1;
              repeat (HoldCycles) @(posedge clk_i);
              sink_hold <= 1'b0;
            end
          join_none
        end
        send_meas(pick_meas(), 1'b0, fixed_out);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/skf_pkg.sv
hdl/skf_apb_regs.sv
hdl/skf_sequencer.sv
hdl/skf_datapath.sv
hdl/scalar_kalman_filter.sv
dv/tb_scalar_kalman_filter.sv
